/* hdl/btlv_pkg.sv */
// btlv_pkg: shared types and codes of the ber-tlv stream parser
// used by btlv_front, btlv_back and ber_tlv_stream_parser; no dependencies
`timescale 1ns / 1ps

package btlv_pkg;

	// byte roles on the result side
	typedef enum logic [1:0] {
		ROLE_TAG     = 2'd0,
		ROLE_LEN     = 2'd1,
		ROLE_LEN_EXT = 2'd2,
		ROLE_VALUE   = 2'd3
	} btlv_role_t;

	// error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_TAG_LONG  = 3'd1;
	localparam logic [2:0] ERR_LEN_LONG  = 3'd2;
	localparam logic [2:0] ERR_TOO_DEEP  = 3'd3;
	localparam logic [2:0] ERR_OVERRUN   = 3'd4;
	localparam logic [2:0] ERR_TRUNCATED = 3'd5;

	// tag bytes kept in the 32-bit tag word
	localparam int TAG_KEEP_BYTES = 4;

	// classified byte passed from front to back
	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic [31:0] pos;
		logic        ext_tag;   // low five bits all ones
		logic        top_bit;   // bit 7
		logic        cons_bit;  // bit 5
		logic        cnt_zero;  // long-form count of zero
		logic        cnt_over;  // long-form count above the limit
	} btlv_item_t;

	// one labelled byte
	typedef struct packed {
		btlv_role_t  role;
		logic [31:0] tag;
		logic        tag_done;
		logic [31:0] vlen;
		logic        len_done;
		logic        cons;
		logic [3:0]  depth;
		logic        elem_end;
		logic [2:0]  err;
	} btlv_result_t;

endpackage

/* hdl/btlv_queue.sv */
// btlv_queue: small register fifo with push/full and pop/empty sides
// generic width and depth; no dependencies
`timescale 1ns / 1ps

module btlv_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/btlv_front.sv */
// btlv_front: input stage, tracks the buffer offset and classifies each byte
// depends on btlv_pkg
`timescale 1ns / 1ps

module btlv_front import btlv_pkg::*; #(
	parameter int MAX_LEN_BYTES = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       full,
	output logic       item_valid,
	output btlv_item_t item,
	input  logic       item_full
);

	logic        valid_s1;
	btlv_item_t  item_s1;
	logic [31:0] pos_q;
	logic        ready_s1, take;

	assign ready_s1   = !valid_s1 || !item_full;
	assign full       = !ready_s1;
	assign take       = push && ready_s1;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	// stage valid and buffer offset, which restarts after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_q    <= '0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
				pos_q    <= final_byte ? '0 : pos_q + 32'd1;
			end else if (!item_full) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// classified beat
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.data     <= data_byte;
			item_s1.last     <= final_byte;
			item_s1.pos      <= pos_q;
			item_s1.ext_tag  <= (data_byte[4:0] == 5'h1f);
			item_s1.top_bit  <= data_byte[7];
			item_s1.cons_bit <= data_byte[5];
			item_s1.cnt_zero <= (data_byte[6:0] == 7'd0);
			item_s1.cnt_over <= (32'(data_byte[6:0]) > MAX_LEN_BYTES);
		end
	end

endmodule

/* hdl/btlv_back.sv */
// btlv_back: parser state machine and level stack, one classified byte per cycle
// while the result queue is not full; depends on btlv_pkg
`timescale 1ns / 1ps

module btlv_back import btlv_pkg::*; #(
	parameter int MAX_DEPTH     = 8,
	parameter int MAX_TAG_BYTES = 4,
	parameter int MAX_LEN_BYTES = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	input  btlv_item_t   item,
	output logic         item_pop,
	input  logic         res_full,
	output logic         res_push,
	output btlv_result_t res
);

	localparam int DW  = $clog2(MAX_DEPTH + 1);
	localparam int IW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int TCW = $clog2(MAX_TAG_BYTES + 1);
	localparam int LBW = $clog2(MAX_LEN_BYTES + 1);

	typedef enum logic [4:0] {
		PH_TAG_FIRST = 5'b00001,
		PH_TAG_MORE  = 5'b00010,
		PH_LEN_FIRST = 5'b00100,
		PH_LEN_MORE  = 5'b01000,
		PH_VALUE     = 5'b10000
	} btlv_phase_t;

	btlv_phase_t    phase_q, phase_n;
	logic [31:0]    tag_q, tag_n;
	logic [TCW-1:0] tcnt_q, tcnt_n;
	logic [LBW-1:0] lbl_q, lbl_n;
	logic [31:0]    acc_q, acc_n;
	logic           cons_q, cons_n;
	logic [31:0]    vend_q, vend_n;
	logic [DW-1:0]  depth_q, depth_n;
	logic [31:0]    stack_q [MAX_DEPTH];

	logic [MAX_DEPTH:0] open_mask;
	logic [DW-1:0]      depth_close, depth_cur;
	logic [DW-1:0]      top_idx;
	logic [31:0]        top_end, bottom_end;
	logic               hdr_ovr;
	logic               fin_req;
	logic [31:0]        fin_len;
	logic [32:0]        end_pos;
	logic               push_lvl;
	logic [32:0]        pos_next;
	btlv_result_t       r;
	logic [7:0]         b;

	assign item_pop = item_valid && !res_full;
	assign res_push = item_pop;
	assign res      = r;
	assign b        = item.data;
	assign pos_next = {1'b0, item.pos} + 33'd1;

	// levels still open at this offset; ends never grow toward the top,
	// so the open ones form a run from the bottom
	always_comb begin
		open_mask = '0;
		for (int i = 0; i < MAX_DEPTH; i++) begin
			open_mask[i] = (DW'(i) < depth_q) && (stack_q[i] > item.pos);
		end
		depth_close = '0;
		for (int i = 0; i < MAX_DEPTH; i++) begin
			if (open_mask[i] && !open_mask[i+1]) begin
				depth_close = depth_close | DW'(i + 1);
			end
		end
	end

	assign depth_cur = (phase_q == PH_TAG_FIRST) ? depth_close : depth_q;
	assign top_idx   = depth_q - 1'b1;
	assign top_end   = (depth_q != '0) ? stack_q[top_idx[IW-1:0]] : 32'd0;
	assign hdr_ovr   = (depth_q != '0) && (item.pos >= top_end);

	// length that completes the header this beat
	always_comb begin
		if (phase_q == PH_LEN_MORE) begin
			fin_len = {acc_q[23:0], b};
		end else if (b[7]) begin
			fin_len = 32'd0;
		end else begin
			fin_len = {24'd0, b};
		end
	end
	assign end_pos = pos_next + {1'b0, fin_len};

	// next state and result of one beat
	always_comb begin
		phase_n    = phase_q;
		tag_n      = tag_q;
		tcnt_n     = tcnt_q;
		lbl_n      = lbl_q;
		acc_n      = acc_q;
		cons_n     = cons_q;
		vend_n     = vend_q;
		depth_n    = depth_cur;
		fin_req    = 1'b0;
		push_lvl   = 1'b0;
		bottom_end = stack_q[0];
		r          = '0;
		r.role     = ROLE_TAG;
		r.err      = ERR_NONE;

		case (phase_q)
			PH_TAG_FIRST: begin
				r.role = ROLE_TAG;
				tag_n  = {24'd0, b};
				tcnt_n = TCW'(1);
				cons_n = item.cons_bit;
				if (item.ext_tag) begin
					phase_n = PH_TAG_MORE;
				end else begin
					r.tag_done = 1'b1;
					phase_n    = PH_LEN_FIRST;
				end
			end
			PH_TAG_MORE: begin
				r.role = ROLE_TAG;
				if (hdr_ovr) begin
					r.err = ERR_OVERRUN;
				end else if (tcnt_q >= TCW'(MAX_TAG_BYTES)) begin
					r.err = ERR_TAG_LONG;
				end else begin
					if (32'(tcnt_q) < TAG_KEEP_BYTES) begin
						tag_n = {tag_q[23:0], b};
					end
					tcnt_n = tcnt_q + 1'b1;
					if (!item.top_bit) begin
						r.tag_done = 1'b1;
						phase_n    = PH_LEN_FIRST;
					end
				end
			end
			PH_LEN_FIRST: begin
				r.role = ROLE_LEN;
				if (hdr_ovr) begin
					r.err = ERR_OVERRUN;
				end else if (item.top_bit) begin
					if (item.cnt_over) begin
						r.err = ERR_LEN_LONG;
					end else if (item.cnt_zero) begin
						fin_req = 1'b1;
					end else begin
						lbl_n   = b[LBW-1:0];
						acc_n   = 32'd0;
						phase_n = PH_LEN_MORE;
					end
				end else begin
					fin_req = 1'b1;
				end
			end
			PH_LEN_MORE: begin
				r.role = ROLE_LEN_EXT;
				if (hdr_ovr) begin
					r.err = ERR_OVERRUN;
				end else if (acc_q[31:24] != 8'd0) begin
					r.err = ERR_LEN_LONG;
				end else begin
					acc_n = fin_len;
					if (lbl_q != '0) begin
						lbl_n = lbl_q - 1'b1;
					end
					if (lbl_n == '0) begin
						fin_req = 1'b1;
					end
				end
			end
			PH_VALUE: begin
				r.role = ROLE_VALUE;
				if (pos_next[31:0] == vend_q) begin
					r.elem_end = 1'b1;
					phase_n    = PH_TAG_FIRST;
				end
			end
			default: begin
				phase_n = PH_TAG_FIRST;
			end
		endcase

		// header complete: place the element
		if (fin_req) begin
			r.len_done = 1'b1;
			r.vlen     = fin_len;
			acc_n      = fin_len;
			if (end_pos[32]) begin
				r.err = ERR_LEN_LONG;
			end else if ((depth_q != '0) && (end_pos > {1'b0, top_end})) begin
				r.err = ERR_OVERRUN;
			end else if (cons_q) begin
				if (depth_q >= DW'(MAX_DEPTH)) begin
					r.err = ERR_TOO_DEEP;
				end else begin
					push_lvl = 1'b1;
					depth_n  = depth_q + 1'b1;
					phase_n  = PH_TAG_FIRST;
					if (depth_q == '0) begin
						bottom_end = end_pos[31:0];
					end
				end
			end else if (fin_len == 32'd0) begin
				r.elem_end = 1'b1;
				phase_n    = PH_TAG_FIRST;
			end else begin
				vend_n  = end_pos[31:0];
				phase_n = PH_VALUE;
			end
		end

		r.tag   = tag_n;
		r.cons  = cons_n;
		r.depth = 4'(depth_cur);

		// recovery after an error
		if (r.err != ERR_NONE) begin
			phase_n  = PH_TAG_FIRST;
			tag_n    = '0;
			tcnt_n   = '0;
			lbl_n    = '0;
			acc_n    = '0;
			cons_n   = 1'b0;
			vend_n   = '0;
			depth_n  = '0;
			push_lvl = 1'b0;
		end

		// end of buffer: check for an open element or level, then restart
		if (item.last) begin
			if (r.err == ERR_NONE) begin
				if (phase_n != PH_TAG_FIRST) begin
					r.err = ERR_TRUNCATED;
				end else if ((depth_n != '0) && ({1'b0, bottom_end} > pos_next)) begin
					r.err = ERR_TRUNCATED;
				end
			end
			phase_n = PH_TAG_FIRST;
			tag_n   = '0;
			tcnt_n  = '0;
			lbl_n   = '0;
			acc_n   = '0;
			cons_n  = 1'b0;
			vend_n  = '0;
			depth_n = '0;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG_FIRST;
			tag_q   <= '0;
			tcnt_q  <= '0;
			lbl_q   <= '0;
			acc_q   <= '0;
			cons_q  <= 1'b0;
			vend_q  <= '0;
			depth_q <= '0;
		end else if (item_pop) begin
			phase_q <= phase_n;
			tag_q   <= tag_n;
			tcnt_q  <= tcnt_n;
			lbl_q   <= lbl_n;
			acc_q   <= acc_n;
			cons_q  <= cons_n;
			vend_q  <= vend_n;
			depth_q <= depth_n;
		end
	end

	// level end stack, written when a constructed element opens
	always_ff @(posedge clk) begin
		if (item_pop && push_lvl) begin
			stack_q[depth_q[IW-1:0]] <= end_pos[31:0];
		end
	end

endmodule

/* hdl/ber_tlv_stream_parser.sv */
// ber_tlv_stream_parser: top level of the ber-tlv byte labeller
// depends on btlv_pkg, btlv_queue, btlv_front and btlv_back
`timescale 1ns / 1ps

// Labels each byte of a BER-TLV buffer as tag, first length, extra length or
// value byte and reports the tag, decoded length, nesting depth and errors.
// One byte is taken per clock cycle while results are popped, with no stall
// from the parser itself; its result reaches the result side through the
// input register, which takes it at the accepting edge, then the
// front-to-back queue and then the result queue. The rate is set by the
// back-end parser, which updates its state and level stack once per byte.
// The last byte of each buffer is marked with final_byte, after which the
// parser starts over at offset zero.

module ber_tlv_stream_parser import btlv_pkg::*; #(
	parameter int MAX_DEPTH     = 8,
	parameter int MAX_TAG_BYTES = 4,
	parameter int MAX_LEN_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  byte_role,
	output logic [31:0] tag_value,
	output logic        tag_done,
	output logic [31:0] value_length,
	output logic        length_done,
	output logic        is_constructed,
	output logic [3:0]  nest_depth,
	output logic        element_end,
	output logic [2:0]  error_code
);

	localparam int QDEPTH = 2;

	logic         front_valid, mid_full, mid_empty, mid_pop;
	btlv_item_t   front_item, mid_item;
	logic         res_push, res_full;
	btlv_result_t back_res, out_res;

	// input stage
	btlv_front #(
		.MAX_LEN_BYTES(MAX_LEN_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.data_byte (data_byte),
		.final_byte(final_byte),
		.full      (full),
		.item_valid(front_valid),
		.item      (front_item),
		.item_full (mid_full)
	);

	// queue between front and back
	btlv_queue #(
		.WIDTH($bits(btlv_item_t)),
		.DEPTH(QDEPTH)
	) u_mid_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (front_valid),
		.wdata (front_item),
		.full  (mid_full),
		.pop   (mid_pop),
		.rdata (mid_item),
		.empty (mid_empty)
	);

	// parser
	btlv_back #(
		.MAX_DEPTH    (MAX_DEPTH),
		.MAX_TAG_BYTES(MAX_TAG_BYTES),
		.MAX_LEN_BYTES(MAX_LEN_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(!mid_empty),
		.item      (mid_item),
		.item_pop  (mid_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (back_res)
	);

	// result queue
	btlv_queue #(
		.WIDTH($bits(btlv_result_t)),
		.DEPTH(QDEPTH)
	) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (back_res),
		.full  (res_full),
		.pop   (pop),
		.rdata (out_res),
		.empty (empty)
	);

	// result beat onto ports
	assign byte_role      = out_res.role;
	assign tag_value      = out_res.tag;
	assign tag_done       = out_res.tag_done;
	assign value_length   = out_res.vlen;
	assign length_done    = out_res.len_done;
	assign is_constructed = out_res.cons;
	assign nest_depth     = out_res.depth;
	assign element_end    = out_res.elem_end;
	assign error_code     = out_res.err;

endmodule

/* tb/sv/btlv_label_checker.sv */
// btlv_label_checker: predicts the label of every byte taken by the ber-tlv parser
// and compares the result beats against it; depends on btlv_pkg only
`timescale 1ns / 1ps

module btlv_label_checker import btlv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  byte_role,
	input  logic [31:0] tag_value,
	input  logic        tag_done,
	input  logic [31:0] value_length,
	input  logic        length_done,
	input  logic        is_constructed,
	input  logic [3:0]  nest_depth,
	input  logic        element_end,
	input  logic [2:0]  error_code,
	output int          mismatches,
	output int          pending,
	output int          bytes_checked,
	output int          buffers_seen,
	output logic [7:0]  err_seen,
	output int          deepest
);

	localparam int LEVELS    = 8;
	localparam int TAG_LIMIT = 4;
	localparam int LEN_LIMIT = 4;

	typedef enum logic [2:0] {
		LOOK_TAG,
		LOOK_TAG_MORE,
		LOOK_LEN,
		LOOK_LEN_MORE,
		LOOK_VALUE
	} look_t;

	// predictor state
	look_t       phase;
	logic [31:0] tag_word;
	logic [2:0]  tag_count;
	logic [2:0]  len_left;
	logic [31:0] len_word;
	logic        cons_now;
	logic [31:0] offset;
	logic [31:0] value_stop;
	logic [31:0] level_ends [0:LEVELS-1];
	logic [3:0]  open_levels;

	btlv_result_t expected_labels [$];
	btlv_result_t want;
	btlv_result_t got;

	// back to the start of an element at top level
	function automatic void clear_parse();
		phase       = LOOK_TAG;
		tag_word    = '0;
		tag_count   = '0;
		len_left    = '0;
		len_word    = '0;
		cons_now    = 1'b0;
		value_stop  = '0;
		open_levels = '0;
	endfunction

	function automatic void reset_model();
		clear_parse();
		offset = '0;
		for (int i = 0; i < LEVELS; i++) level_ends[i] = '0;
	endfunction

	function automatic logic [31:0] top_limit();
		if (open_levels == 0)
			return '0;
		return level_ends[open_levels - 1];
	endfunction

	// drop every level whose end has been reached
	function automatic void close_to(input logic [32:0] p);
		while (open_levels != 0 && {1'b0, top_limit()} <= p)
			open_levels = open_levels - 1;
	endfunction

	function automatic logic header_past(input logic [31:0] pos);
		return open_levels != 0 && pos >= top_limit();
	endfunction

	// length field complete: open a level, end the element, go to the value or fail
	function automatic logic [2:0] settle_length(input logic [31:0] pos,
			input logic [31:0] len, output logic done_elem);
		logic [32:0] stop;
		stop      = {1'b0, pos} + 33'd1 + {1'b0, len};
		len_word  = len;
		done_elem = 1'b0;
		if (stop[32])
			return ERR_LEN_LONG;
		if (open_levels != 0 && stop > {1'b0, top_limit()})
			return ERR_OVERRUN;
		if (cons_now) begin
			if (open_levels >= LEVELS)
				return ERR_TOO_DEEP;
			level_ends[open_levels[2:0]] = stop[31:0];
			open_levels = open_levels + 1;
			phase = LOOK_TAG;
		end else if (len == 0) begin
			done_elem = 1'b1;
			phase = LOOK_TAG;
		end else begin
			value_stop = stop[31:0];
			phase = LOOK_VALUE;
		end
		return ERR_NONE;
	endfunction

	// label one byte and advance the predictor
	function automatic btlv_result_t label_byte(input logic [7:0] b, input logic fin);
		btlv_result_t r;
		logic [31:0]  pos;
		logic [2:0]   err;
		logic         elem_done;
		logic [6:0]   cnt;
		r         = '0;
		pos       = offset;
		err       = ERR_NONE;
		elem_done = 1'b0;
		if (phase == LOOK_TAG)
			close_to({1'b0, pos});
		r.depth = open_levels;
		case (phase)
			LOOK_TAG: begin
				r.role    = ROLE_TAG;
				tag_word  = {24'd0, b};
				tag_count = 3'd1;
				cons_now  = b[5];
				if (b[4:0] == 5'h1f) begin
					phase = LOOK_TAG_MORE;
				end else begin
					r.tag_done = 1'b1;
					phase = LOOK_LEN;
				end
			end
			LOOK_TAG_MORE: begin
				r.role = ROLE_TAG;
				if (header_past(pos)) begin
					err = ERR_OVERRUN;
				end else if (tag_count >= TAG_LIMIT) begin
					err = ERR_TAG_LONG;
				end else begin
					if (tag_count < TAG_KEEP_BYTES)
						tag_word = {tag_word[23:0], b};
					tag_count = tag_count + 1;
					if (!b[7]) begin
						r.tag_done = 1'b1;
						phase = LOOK_LEN;
					end
				end
			end
			LOOK_LEN: begin
				r.role = ROLE_LEN;
				if (header_past(pos)) begin
					err = ERR_OVERRUN;
				end else if (b[7]) begin
					cnt = b[6:0];
					if (cnt > LEN_LIMIT) begin
						err = ERR_LEN_LONG;
					end else if (cnt == 0) begin
						r.len_done = 1'b1;
						err = settle_length(pos, 32'd0, elem_done);
					end else begin
						len_left = cnt[2:0];
						len_word = '0;
						phase = LOOK_LEN_MORE;
					end
				end else begin
					r.len_done = 1'b1;
					r.vlen = {24'd0, b};
					err = settle_length(pos, {24'd0, b}, elem_done);
				end
			end
			LOOK_LEN_MORE: begin
				r.role = ROLE_LEN_EXT;
				if (header_past(pos)) begin
					err = ERR_OVERRUN;
				end else if (len_word[31:24] != 0) begin
					err = ERR_LEN_LONG;
				end else begin
					len_word = {len_word[23:0], b};
					if (len_left != 0)
						len_left = len_left - 1;
					if (len_left == 0) begin
						r.len_done = 1'b1;
						r.vlen = len_word;
						err = settle_length(pos, len_word, elem_done);
					end
				end
			end
			default: begin
				r.role = ROLE_VALUE;
				if (pos + 32'd1 == value_stop) begin
					elem_done = 1'b1;
					phase = LOOK_TAG;
				end
			end
		endcase
		r.tag  = tag_word;
		r.cons = cons_now;
		if (err != ERR_NONE)
			clear_parse();
		// end of buffer: anything left open is truncated
		if (fin) begin
			if (err == ERR_NONE) begin
				if (phase == LOOK_TAG)
					close_to({1'b0, pos} + 33'd1);
				if (phase != LOOK_TAG || open_levels != 0)
					err = ERR_TRUNCATED;
			end
			reset_model();
		end else begin
			offset = pos + 32'd1;
		end
		r.elem_end = elem_done;
		r.err = err;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
			mismatches++;
		end
	endtask

	// predict on every input beat, compare on every result beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_model();
			expected_labels.delete();
			mismatches    = 0;
			pending       = 0;
			bytes_checked = 0;
			buffers_seen  = 0;
			err_seen      = '0;
			deepest       = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_labels.size() == 0) begin
					$error("result beat with no label expected");
					mismatches++;
				end else begin
					want = expected_labels.pop_front();
					check_field("byte_role", want.role, byte_role);
					check_field("tag_value", want.tag, tag_value);
					check_field("tag_done", want.tag_done, tag_done);
					check_field("value_length", want.vlen, value_length);
					check_field("length_done", want.len_done, length_done);
					check_field("is_constructed", want.cons, is_constructed);
					check_field("nest_depth", want.depth, nest_depth);
					check_field("element_end", want.elem_end, element_end);
					check_field("error_code", want.err, error_code);
				end
			end
			if (push && !full) begin
				got = label_byte(data_byte, final_byte);
				expected_labels.push_back(got);
				bytes_checked++;
				if (final_byte)
					buffers_seen++;
				err_seen[got.err] = 1'b1;
				if (got.depth > deepest)
					deepest = got.depth;
			end
			pending = expected_labels.size();
		end
	end

endmodule

/* tb/sv/tb_ber_tlv_stream_parser.sv */
// tb_ber_tlv_stream_parser: stimulus and verdict for the ber-tlv stream parser
// depends on btlv_pkg, ber_tlv_stream_parser and btlv_label_checker
`timescale 1ns / 1ps

module tb_ber_tlv_stream_parser;
	import btlv_pkg::*;

	localparam int STUCK_LIMIT = 2000;
	localparam int PHASE_BYTES = 175;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        push       = 1'b0;
	logic [7:0]  data_byte  = '0;
	logic        final_byte = 1'b0;
	logic        pop        = 1'b0;
	logic        full;
	logic        empty;
	logic [1:0]  byte_role;
	logic [31:0] tag_value;
	logic        tag_done;
	logic [31:0] value_length;
	logic        length_done;
	logic        is_constructed;
	logic [3:0]  nest_depth;
	logic        element_end;
	logic [2:0]  error_code;

	int          mismatches;
	int          pending;
	int          bytes_checked;
	int          buffers_seen;
	logic [7:0]  err_seen;
	int          deepest;

	int          idle_pct  = 0;
	int          stall_pct = 0;
	int          bytes_sent = 0;
	logic [7:0]  stream_q [$];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	ber_tlv_stream_parser dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.data_byte      (data_byte),
		.final_byte     (final_byte),
		.empty          (empty),
		.pop            (pop),
		.byte_role      (byte_role),
		.tag_value      (tag_value),
		.tag_done       (tag_done),
		.value_length   (value_length),
		.length_done    (length_done),
		.is_constructed (is_constructed),
		.nest_depth     (nest_depth),
		.element_end    (element_end),
		.error_code     (error_code)
	);

	btlv_label_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.data_byte      (data_byte),
		.final_byte     (final_byte),
		.empty          (empty),
		.pop            (pop),
		.byte_role      (byte_role),
		.tag_value      (tag_value),
		.tag_done       (tag_done),
		.value_length   (value_length),
		.length_done    (length_done),
		.is_constructed (is_constructed),
		.nest_depth     (nest_depth),
		.element_end    (element_end),
		.error_code     (error_code),
		.mismatches     (mismatches),
		.pending        (pending),
		.bytes_checked  (bytes_checked),
		.buffers_seen   (buffers_seen),
		.err_seen       (err_seen),
		.deepest        (deepest)
	);

	// result side stalls at random
	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= stall_pct);
	end

	// one input beat; returns on the falling edge after acceptance, push still high
	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push       <= 1'b1;
		data_byte  <= b;
		final_byte <= fin;
		@(posedge clk);
		while (full) @(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_stream();
		for (int i = 0; i < stream_q.size(); i++)
			send_byte(stream_q[i], i == stream_q.size() - 1);
	endtask

	// hold the sender until every label has come back
	task automatic drain();
		push <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	// tag and length in front of the content that starts at index at
	function automatic void put_header(input int at, input logic [7:0] t,
			input int extra, input int len);
		logic [7:0] hdr [0:11];
		int n;
		int need;
		int cnt;
		n = 0;
		hdr[n] = t;
		n++;
		for (int i = 0; i < extra; i++) begin
			hdr[n] = $urandom;
			hdr[n][7] = (i != extra - 1);
			n++;
		end
		if (len == 0 && $urandom_range(3) == 0) begin
			hdr[n] = 8'h80;
			n++;
		end else if (len < 128 && $urandom_range(3) != 0) begin
			hdr[n] = len[7:0];
			n++;
		end else begin
			need = (len > 'hffffff) ? 4 : (len > 'hffff) ? 3 : (len > 'hff) ? 2 : 1;
			cnt = $urandom_range(4, need);
			hdr[n] = 8'h80 | cnt[7:0];
			n++;
			for (int i = cnt - 1; i >= 0; i--) begin
				hdr[n] = len >> (8 * i);
				n++;
			end
		end
		for (int i = n - 1; i >= 0; i--)
			stream_q.insert(at, hdr[i]);
	endfunction

	// one well-formed top element; the first chain levels are forced constructed
	function automatic void build_tree(input int chain);
		int         frame_at    [0:15];
		logic [7:0] frame_tag   [0:15];
		int         frame_extra [0:15];
		int         frame_kids  [0:15];
		int         sp;
		int         at;
		int         len;
		int         extra;
		logic [7:0] t;
		logic       cons;
		logic       done;
		sp   = 0;
		done = 1'b0;
		while (!done) begin
			cons = (sp < chain) || (sp < 3 && $urandom_range(2) == 0);
			t = $urandom;
			t[5] = cons;
			if ($urandom_range(3) == 0) begin
				t[4:0] = 5'h1f;
				extra = $urandom_range(1, 3);
			end else begin
				t[4:0] = $urandom_range(30);
				extra = 0;
			end
			if (cons) begin
				frame_at[sp]    = stream_q.size();
				frame_tag[sp]   = t;
				frame_extra[sp] = extra;
				frame_kids[sp]  = (sp < chain) ? 1 : $urandom_range(0, 3);
				sp++;
			end else begin
				at  = stream_q.size();
				len = ($urandom_range(29) == 0) ? $urandom_range(120, 300) : $urandom_range(6);
				for (int i = 0; i < len; i++)
					stream_q.push_back($urandom);
				put_header(at, t, extra, len);
				if (sp == 0)
					done = 1'b1;
				else
					frame_kids[sp - 1]--;
			end
			// close every constructed element whose children are all out
			while (!done && sp > 0 && frame_kids[sp - 1] == 0) begin
				sp--;
				put_header(frame_at[sp], frame_tag[sp], frame_extra[sp],
					stream_q.size() - frame_at[sp]);
				if (sp == 0)
					done = 1'b1;
				else
					frame_kids[sp - 1]--;
			end
		end
	endfunction

	// a buffer: mostly clean trees, sometimes cut short, corrupted or pure noise
	task automatic random_buffer(input int chain);
		int pick;
		int keep;
		stream_q.delete();
		for (int i = $urandom_range(1, 3); i > 0; i--)
			build_tree((i == 1) ? chain : 0);
		pick = $urandom_range(99);
		if (pick < 8) begin
			keep = $urandom_range(1, stream_q.size());
			while (stream_q.size() > keep) void'(stream_q.pop_back());
		end else if (pick < 16) begin
			stream_q[$urandom_range(stream_q.size() - 1)] = $urandom;
		end else if (pick < 24) begin
			stream_q.delete();
			for (int i = $urandom_range(1, 16); i > 0; i--)
				stream_q.push_back($urandom);
		end
		send_stream();
	endtask

	// watchdog: too long without any beat on either side
	initial begin
		int stuck;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				stuck = 0;
			else
				stuck++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int idle_sets [0:3];
		int stall_sets [0:3];
		idle_sets  = '{0, 48, 0, 26};
		stall_sets = '{0, 0, 48, 26};
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// directed: clean primitive with extreme value byte
		stream_q = '{8'h5a, 8'h01, 8'hff};
		send_stream();
		// tag longer than four bytes
		stream_q = '{8'h1f, 8'hff, 8'hff, 8'hff, 8'hff};
		send_stream();
		// long-form count above the limit
		stream_q = '{8'h04, 8'h85};
		send_stream();
		// end position past the 32-bit range
		stream_q = '{8'h04, 8'h84, 8'hff, 8'hff, 8'hff, 8'hff};
		send_stream();
		// indefinite form taken as zero length
		stream_q = '{8'h04, 8'h80};
		send_stream();
		// child value overruns its parent
		stream_q = '{8'h20, 8'h02, 8'h04, 8'h05};
		send_stream();
		// buffer ends inside a value
		stream_q = '{8'h00, 8'h05, 8'h00};
		send_stream();

		// random part, one idling pattern per phase
		for (int ph = 0; ph < 4; ph++) begin
			drain();
			idle_pct  = idle_sets[ph];
			stall_pct = stall_sets[ph];
			if (ph == 0) begin
				// nesting right up to and past the level limit
				random_buffer(7);
				random_buffer(8);
				random_buffer(9);
			end
			while (bytes_sent < 25 + (ph + 1) * PHASE_BYTES)
				random_buffer(($urandom_range(9) == 0) ? $urandom_range(5, 9) : 0);
		end

		drain();
		repeat (8) @(negedge clk);
		$display("covered %0d bytes in %0d buffers over four idling patterns,",
			bytes_checked, buffers_seen);
		$display("error codes seen (one bit per code) %b, deepest level %0d",
			err_seen[5:0], deepest);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* files.f */
hdl/btlv_pkg.sv
hdl/btlv_queue.sv
hdl/btlv_front.sv
hdl/btlv_back.sv
hdl/ber_tlv_stream_parser.sv
tb/sv/btlv_label_checker.sv
tb/sv/tb_ber_tlv_stream_parser.sv
